[hw/rtl/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's checkers.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define TTAD_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication that must hold in the following cycle.
`define TTAD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hw/rtl/ttad_pkg.sv]
// -----------------------------------------------------------------------------
// Tensor transpose addressing package
// Word types, field widths and register indexes shared by the block.
// -----------------------------------------------------------------------------
package ttad_pkg;

	localparam int MAX_DIMS   = 4;
	localparam int SIZE_W     = 9;
	localparam int RANK_W     = 3;
	localparam int PERM_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int ADDR_W     = 32;
	localparam int WORD_W     = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_RANK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERM   = 3'd5;

	localparam logic [RANK_W-1:0] RANK_RESET = 3'd1;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd1;
	localparam logic [PERM_W-1:0] PERM_RESET = 8'd228;

	typedef struct packed {
		logic [WORD_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] dest_address;
		logic [WORD_W-1:0] elem_word;
		logic              last;
	} out_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_word_t;

endpackage

[hw/rtl/ttad_chan_if.sv]
// -----------------------------------------------------------------------------
// Valid/ready channel
// One word moves at each clock edge at which valid and ready are both high.
// -----------------------------------------------------------------------------
interface ttad_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/tensor_transpose_addressing_core.sv]
// -----------------------------------------------------------------------------
// Tensor transpose addressing core
// A result word is registered and offered in the cycle after its input word is
// accepted, and one word is taken every cycle while the output side keeps up.
// After reset and after every configuration write the input stays stalled
// while the per-dimension address steps are rebuilt, one 32x9 multiply per
// cycle. Reset and listed register writes restart the source counter at zero.
// -----------------------------------------------------------------------------
module tensor_transpose_addressing_core #(
	parameter int MAX_RANK = 4,
	parameter int DIM_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	ttad_chan_if.sink   cfg_ch,
	ttad_chan_if.sink   in_ch,
	ttad_chan_if.source out_ch
);
	import ttad_pkg::*;

	localparam int NDIM = (MAX_RANK < MAX_DIMS) ? MAX_RANK : MAX_DIMS;
	localparam int IDX_W = (NDIM > 1) ? $clog2(NDIM) : 1;
	localparam int unsigned LIM = 32'd1 << DIM_BITS;

	typedef enum logic [2:0] {
		ST_STRIDE = 3'b001,
		ST_DELTA  = 3'b010,
		ST_READY  = 3'b100
	} bld_state_t;

	bld_state_t          state_q;
	logic [IDX_W-1:0]    step_q;
	logic [ADDR_W-1:0]   acc_q;
	logic [ADDR_W-1:0]   corr_q;
	logic [ADDR_W-1:0]   weight_q [NDIM];
	logic [ADDR_W-1:0]   delta_q [NDIM];
	logic [RANK_W-1:0]   rank_q;
	logic [SIZE_W-1:0]   size_q [MAX_DIMS];
	logic [PERM_W-1:0]   perm_q;
	logic [DIM_BITS-1:0] digit_q [NDIM];
	logic [ADDR_W-1:0]   addr_q;
	logic                out_valid_q;
	out_word_t           out_word_q;

	logic                cfg_acc;
	logic                cfg_listed;
	logic                in_ready;
	logic                in_acc;
	logic                last_step;
	logic [RANK_W-1:0]   urank;
	logic [1:0]          src_dim;
	logic                src_in_use;
	logic [SIZE_W-1:0]   ext_src;
	logic [SIZE_W-1:0]   ext_step;
	logic [40:0]         acc_prod;
	logic [40:0]         corr_prod;
	logic [NDIM-1:0]     wrap;
	logic                final_elem;
	logic [ADDR_W-1:0]   step_delta;
	logic [DIM_BITS-1:0] digit_nxt [NDIM];
	logic [ADDR_W-1:0]   addr_nxt;

	function automatic logic [SIZE_W-1:0] ext_of(input int unsigned d,
		input logic [RANK_W-1:0] ur, input logic [SIZE_W-1:0] sz);
		logic [SIZE_W-1:0] e;
		if (d >= 32'(ur)) begin
			e = SIZE_W'(1);
		end else if (sz == '0) begin
			e = SIZE_W'(1);
		end else if ((DIM_BITS < SIZE_W) && (32'(sz) > LIM)) begin
			e = SIZE_W'(LIM);
		end else begin
			e = sz;
		end
		return e;
	endfunction

	assign cfg_acc    = cfg_ch.valid && cfg_ch.ready;
	assign cfg_listed = cfg_ch.payload.index inside {[CFG_RANK:CFG_PERM]};
	assign in_ready   = (state_q == ST_READY) && (!out_valid_q || out_ch.ready);
	assign in_acc     = in_ch.valid && in_ready;
	assign last_step  = (step_q == IDX_W'(NDIM - 1));

	assign cfg_ch.ready  = 1'b1;
	assign in_ch.ready   = in_ready;
	assign out_ch.valid  = out_valid_q;
	assign out_ch.payload = out_word_q;

	assign urank = (rank_q == '0) ? RANK_W'(1) :
		(32'(rank_q) > NDIM) ? RANK_W'(NDIM) : rank_q;

	assign src_dim    = perm_q[2 * int'(step_q) +: 2];
	assign src_in_use = 32'(step_q) < 32'(urank);
	assign ext_src    = ext_of(32'(src_dim), urank, size_q[src_dim]);
	assign ext_step   = ext_of(32'(step_q), urank, size_q[2'(step_q)]);
	assign acc_prod   = 41'(acc_q) * 41'(ext_src);
	assign corr_prod  = 41'(weight_q[step_q]) * 41'(ext_step - SIZE_W'(1));

	always_comb begin
		logic             carry;
		logic [SIZE_W-1:0] ext_d;
		carry      = 1'b1;
		step_delta = '0;
		for (int d = 0; d < NDIM; d++) begin
			ext_d        = ext_of(32'(d), urank, size_q[2'(d)]);
			wrap[d]      = (32'(digit_q[d]) + 32'd1) >= 32'(ext_d);
			digit_nxt[d] = digit_q[d];
			if (carry) begin
				if (wrap[d]) begin
					digit_nxt[d] = '0;
				end else begin
					digit_nxt[d] = digit_q[d] + DIM_BITS'(1);
					step_delta   = delta_q[d];
					carry        = 1'b0;
				end
			end
		end
		final_elem = &wrap;
		addr_nxt   = final_elem ? '0 : addr_q + step_delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_STRIDE;
			step_q   <= '0;
			acc_q    <= ADDR_W'(1);
			corr_q   <= '0;
			for (int d = 0; d < NDIM; d++) begin
				weight_q[d] <= '0;
			end
		end else if (cfg_acc) begin
			state_q  <= ST_STRIDE;
			step_q   <= '0;
			acc_q    <= ADDR_W'(1);
			corr_q   <= '0;
			for (int d = 0; d < NDIM; d++) begin
				weight_q[d] <= '0;
			end
		end else begin
			case (state_q)
				ST_STRIDE: begin
					if (src_in_use) begin
						acc_q <= acc_prod[ADDR_W-1:0];
						if (32'(src_dim) < NDIM) begin
							weight_q[IDX_W'(src_dim)] <= weight_q[IDX_W'(src_dim)] + acc_q;
						end
					end
					if (last_step) begin
						state_q <= ST_DELTA;
						step_q  <= '0;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				ST_DELTA: begin
					corr_q <= corr_q + corr_prod[ADDR_W-1:0];
					if (last_step) begin
						state_q <= ST_READY;
						step_q  <= '0;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				ST_READY: begin
					state_q <= ST_READY;
				end
				default: begin
					state_q <= ST_STRIDE;
					step_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!cfg_acc && (state_q == ST_DELTA)) begin
			delta_q[step_q] <= weight_q[step_q] - corr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_RESET;
			perm_q <= PERM_RESET;
			for (int d = 0; d < MAX_DIMS; d++) begin
				size_q[d] <= SIZE_RESET;
			end
		end else if (cfg_acc) begin
			case (cfg_ch.payload.index)
				CFG_RANK:   rank_q    <= cfg_ch.payload.data[RANK_W-1:0];
				CFG_SIZE_0: size_q[0] <= cfg_ch.payload.data;
				CFG_SIZE_1: size_q[1] <= cfg_ch.payload.data;
				CFG_SIZE_2: size_q[2] <= cfg_ch.payload.data;
				CFG_SIZE_3: size_q[3] <= cfg_ch.payload.data;
				CFG_PERM:   perm_q    <= cfg_ch.payload.data[PERM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			for (int d = 0; d < NDIM; d++) begin
				digit_q[d] <= '0;
			end
		end else if (cfg_acc && cfg_listed) begin
			addr_q <= '0;
			for (int d = 0; d < NDIM; d++) begin
				digit_q[d] <= '0;
			end
		end else if (in_acc) begin
			addr_q <= addr_nxt;
			for (int d = 0; d < NDIM; d++) begin
				digit_q[d] <= digit_nxt[d];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_word_q.dest_address <= addr_q;
			out_word_q.elem_word    <= in_ch.payload.value;
			out_word_q.last         <= final_elem;
		end
	end

endmodule

[hw/rtl/ttad_checker.sv]
// -----------------------------------------------------------------------------
// Tensor transpose addressing checker
// Port-level timing checks of the core's channels, bound into the core module.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttad_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_valid,
	input logic cfg_ready
);

	// A result word that is not taken stays offered.
	`TTAD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out dropped")

	// An accepted input word shows up as a result word in the next cycle.
	`TTAD_ASSERT_NEXT(a_in_to_out, clk, arst_n, in_valid && in_ready, out_valid, "no result")

	// The input is only taken when the result slot is free or being drained.
	`TTAD_ASSERT_NOW(a_slot_free, clk, arst_n, in_ready, !out_valid || out_ready, "slot busy")

	// A register write stalls the input while the address steps are rebuilt.
	`TTAD_ASSERT_NEXT(a_cfg_stall, clk, arst_n, cfg_valid && cfg_ready, !in_ready, "no rebuild")

endmodule

bind tensor_transpose_addressing_core ttad_checker u_ttad_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.cfg_valid (cfg_ch.valid),
	.cfg_ready (cfg_ch.ready)
);

[tb/sv/tb_tensor_transpose_addressing_core.sv]
// -----------------------------------------------------------------------------
// Tensor transpose addressing core testbench
// Streams element words through the core under a range of tensor shapes,
// permutations and register settings. The expected destination address,
// element word and last flag of every word are predicted in the testbench
// and checked as result words leave. Sender gaps and receiver stalls vary
// from phase to phase.
// -----------------------------------------------------------------------------
module tb_tensor_transpose_addressing_core;
	import ttad_pkg::*;

	localparam int DIM_BITS  = 8;
	localparam int DIM_LIMIT = 1 << DIM_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	ttad_chan_if #(.payload_t(cfg_word_t)) cfg_if ();
	ttad_chan_if #(.payload_t(in_word_t))  in_if ();
	ttad_chan_if #(.payload_t(out_word_t)) out_if ();

	tensor_transpose_addressing_core #(
		.MAX_RANK(MAX_DIMS),
		.DIM_BITS(DIM_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_ch(cfg_if),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Shadow copy of the registers and the address state.
	logic [RANK_W-1:0] m_rank;
	logic [SIZE_W-1:0] m_size [MAX_DIMS];
	logic [PERM_W-1:0] m_perm;
	logic [7:0]        m_digit [MAX_DIMS];
	logic [31:0]       m_stride [MAX_DIMS];

	out_word_t expected_words [$];
	int unsigned words_sent;
	int unsigned words_checked;
	int unsigned failures;
	int unsigned idle_pct;
	int unsigned stall_pct;

	function automatic int unsigned eff_rank();
		int unsigned r;
		r = m_rank;
		if (r < 1) r = 1;
		if (r > MAX_DIMS) r = MAX_DIMS;
		return r;
	endfunction

	function automatic logic [31:0] eff_extent(input int unsigned d);
		logic [31:0] s;
		if (d >= eff_rank()) return 32'd1;
		s = m_size[d];
		if (s == 0) s = 1;
		if (s > DIM_LIMIT) s = DIM_LIMIT;
		return s;
	endfunction

	function automatic int unsigned src_of(input int unsigned i);
		return m_perm[2*i +: 2];
	endfunction

	function automatic void rebuild_strides();
		logic [31:0] acc;
		acc = 32'd1;
		for (int i = 0; i < MAX_DIMS; i++) begin
			m_stride[i] = acc;
			if (i < eff_rank()) acc = acc * eff_extent(src_of(i));
		end
	endfunction

	function automatic void clear_digits();
		for (int i = 0; i < MAX_DIMS; i++) m_digit[i] = 8'd0;
	endfunction

	function automatic void reset_shadow();
		m_rank = RANK_RESET;
		for (int i = 0; i < MAX_DIMS; i++) m_size[i] = SIZE_RESET;
		m_perm = PERM_RESET;
		clear_digits();
		rebuild_strides();
	endfunction

	// Writes to indexes beyond the register list only rebuild the strides.
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
		CFG_RANK: m_rank = data[RANK_W-1:0];
		CFG_SIZE_0: m_size[0] = data;
		CFG_SIZE_1: m_size[1] = data;
		CFG_SIZE_2: m_size[2] = data;
		CFG_SIZE_3: m_size[3] = data;
		CFG_PERM: m_perm = data[PERM_W-1:0];
		default: begin
			rebuild_strides();
			return;
		end
		endcase
		clear_digits();
		rebuild_strides();
	endfunction

	function automatic out_word_t transpose_elem(input logic [WORD_W-1:0] v);
		int unsigned r;
		logic [31:0] addr;
		logic [31:0] dig;
		logic at_end;
		out_word_t w;
		r = eff_rank();
		addr = 32'd0;
		at_end = 1'b1;
		for (int i = 0; i < r; i++) begin
			dig = (src_of(i) < r) ? m_digit[src_of(i)] : 32'd0;
			addr = addr + dig * m_stride[i];
		end
		for (int i = 0; i < r; i++) begin
			if (m_digit[i] + 1 < eff_extent(i)) at_end = 1'b0;
		end
		for (int i = 0; i < r; i++) begin
			if (m_digit[i] + 1 >= eff_extent(i)) begin
				m_digit[i] = 8'd0;
			end else begin
				m_digit[i] = m_digit[i] + 8'd1;
				break;
			end
		end
		w.dest_address = addr;
		w.elem_word = v;
		w.last = at_end;
		return w;
	endfunction

	function automatic longint tensor_len();
		longint n;
		n = 1;
		for (int d = 0; d < MAX_DIMS; d++) n = n * eff_extent(d);
		return n;
	endfunction

	always @(posedge clk) begin
		out_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		out_word_t want;
		out_word_t pred;
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				pred = transpose_elem(in_if.payload.value);
				expected_words = {expected_words, pred};
			end
			if (out_if.valid && out_if.ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word: dest_address %0h", out_if.payload.dest_address);
					failures++;
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					if (out_if.payload.dest_address !== want.dest_address) begin
						$error("dest_address: expected %0h, actual %0h",
							want.dest_address, out_if.payload.dest_address);
						failures++;
					end
					if (out_if.payload.elem_word !== want.elem_word) begin
						$error("elem_word: expected %0h, actual %0h",
							want.elem_word, out_if.payload.elem_word);
						failures++;
					end
					if (out_if.payload.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, out_if.payload.last);
						failures++;
					end
				end
			end
		end
	end

	task automatic hold_until_drained();
		in_if.valid <= 1'b0;
		do @(posedge clk); while (words_sent != words_checked);
	endtask

	task automatic send_elem(input logic [WORD_W-1:0] v);
		if ($urandom_range(99) < idle_pct) begin
			in_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_if.valid <= 1'b1;
		in_if.payload.value <= v;
		do @(posedge clk); while (!in_if.ready);
		words_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.payload.index <= idx;
		cfg_if.payload.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		apply_reg(idx, data);
	endtask

	task automatic configure(input logic [RANK_W-1:0] rk, input logic [SIZE_W-1:0] s0,
			input logic [SIZE_W-1:0] s1, input logic [SIZE_W-1:0] s2,
			input logic [SIZE_W-1:0] s3, input logic [PERM_W-1:0] pm);
		hold_until_drained();
		write_reg(CFG_RANK, CFG_DATA_W'(rk));
		write_reg(CFG_SIZE_0, s0);
		write_reg(CFG_SIZE_1, s1);
		write_reg(CFG_SIZE_2, s2);
		write_reg(CFG_SIZE_3, s3);
		write_reg(CFG_PERM, CFG_DATA_W'(pm));
		cfg_if.valid <= 1'b0;
	endtask

	task automatic poke_unlisted(input logic [CFG_IDX_W-1:0] idx);
		hold_until_drained();
		write_reg(idx, CFG_DATA_W'($urandom));
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send_burst(input int unsigned n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0) hold_until_drained();
			send_elem({$urandom, $urandom});
		end
	endtask

	task automatic random_config();
		logic [RANK_W-1:0] rk;
		logic [SIZE_W-1:0] sz [MAX_DIMS];
		logic [PERM_W-1:0] pm;
		int unsigned order [MAX_DIMS];
		int unsigned j;
		int unsigned t;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) rk = 3'd0;
		else if (pick == 1) rk = RANK_W'($urandom_range(5, 7));
		else rk = RANK_W'($urandom_range(1, 4));
		for (int d = 0; d < MAX_DIMS; d++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) sz[d] = 9'd0;
			else if (pick == 1) sz[d] = SIZE_W'($urandom_range(257, 511));
			else if (pick == 2) sz[d] = SIZE_W'($urandom_range(200, 256));
			else sz[d] = SIZE_W'($urandom_range(1, 4));
		end
		if ($urandom_range(0, 3) == 0) begin
			pm = PERM_W'($urandom);
		end else begin
			for (int i = 0; i < MAX_DIMS; i++) order[i] = i;
			for (int i = MAX_DIMS - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = order[i];
				order[i] = order[j];
				order[j] = t;
			end
			pm = '0;
			for (int i = 0; i < MAX_DIMS; i++) pm[2*i +: 2] = order[i][1:0];
		end
		configure(rk, sz[0], sz[1], sz[2], sz[3], pm);
	endtask

	task automatic run_random_phase(input int unsigned gap, input int unsigned stall,
			input int unsigned n);
		int unsigned sent;
		longint len;
		int unsigned cnt;
		idle_pct = gap;
		stall_pct = stall;
		sent = 0;
		while (sent < n) begin
			random_config();
			if ($urandom_range(0, 7) == 0)
				poke_unlisted($urandom_range(0, 1) ? CFG_UNUSED_7 : CFG_UNUSED_6);
			len = tensor_len();
			if (len <= 48) begin
				cnt = int'(len) * $urandom_range(1, 3);
				if ($urandom_range(0, 3) == 0) cnt += $urandom_range(0, int'(len) - 1);
			end else begin
				cnt = $urandom_range(4, 30);
			end
			send_burst(cnt);
			sent += cnt;
		end
	endtask

	task automatic test_reset_state();
		idle_pct = 0;
		stall_pct = 0;
		send_elem(64'h0);
		send_elem('1);
	endtask

	task automatic test_swapped_matrix();
		configure(3'd2, 9'd3, 9'd2, 9'd1, 9'd1, 8'hE1);
		send_elem(64'h5555_5555_5555_5555);
		send_elem(64'hAAAA_AAAA_AAAA_AAAA);
		send_burst(4);
	endtask

	task automatic test_clamped_fields();
		// Rank zero behaves as one; the sizes of unused dimensions do not matter.
		configure(3'd0, 9'd3, 9'd5, 9'd0, 9'd511, PERM_RESET);
		send_burst(3);
		// Rank above four, a zero size and an oversized extent.
		configure(3'd7, 9'd2, 9'd0, 9'd2, 9'd511, 8'h1B);
		send_burst(4);
		// A permutation that names dimension zero at every position.
		configure(3'd3, 9'd2, 9'd2, 9'd1, 9'd1, 8'h00);
		send_burst(4);
	endtask

	task automatic test_largest_tensor();
		configure(3'd4, 9'd256, 9'd256, 9'd256, 9'd256, 8'h1B);
		send_burst(3);
	endtask

	task automatic test_unlisted_write();
		configure(3'd2, 9'd2, 9'd2, 9'd1, 9'd1, PERM_RESET);
		send_burst(2);
		poke_unlisted(CFG_UNUSED_6);
		send_burst(2);
		poke_unlisted(CFG_UNUSED_7);
		send_burst(1);
	endtask

	task automatic test_random_no_idle();
		run_random_phase(0, 0, 85);
	endtask

	task automatic test_random_sender_idle();
		run_random_phase(65, 0, 85);
	endtask

	task automatic test_random_receiver_stall();
		run_random_phase(0, 65, 85);
	endtask

	task automatic test_random_both_idle();
		run_random_phase(32, 32, 85);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		in_if.valid = 1'b0;
		in_if.payload = '0;
		out_if.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		words_sent = 0;
		words_checked = 0;
		failures = 0;
		reset_shadow();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_swapped_matrix();
		test_clamped_fields();
		test_largest_tensor();
		test_unlisted_write();
		test_random_no_idle();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (failures == 0 && expected_words.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ttad_pkg.sv
hw/rtl/ttad_chan_if.sv
hw/rtl/tensor_transpose_addressing_core.sv
hw/rtl/ttad_checker.sv
tb/sv/tb_tensor_transpose_addressing_core.sv
